/* rtl/core/tic_pkg.sv */
package tic_pkg;

  // Tensor shape limits and the field widths that follow from them.
  localparam int MAX_DIMS   = 4;
  localparam int MAX_EXTENT = 256;
  localparam int NUM_DIMS   = MAX_DIMS;
  localparam int DIV_DIMS   = NUM_DIMS - 1;
  localparam int EXT_W      = $clog2(MAX_EXTENT + 1);
  localparam int CRD_W      = EXT_W;
  localparam int DIG_W      = $clog2(MAX_EXTENT);
  localparam int DIMS_W     = $clog2(MAX_DIMS + 1);
  localparam int DIDX_W     = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
  localparam int OFF_W      = 32;
  localparam int ACT_W      = 2;

  // Each division by an extent is spread over DIV_SUBSTAGES pipeline stages.
  localparam int DIV_SUBSTAGES      = 4;
  localparam int SUB_W              = $clog2(DIV_SUBSTAGES);
  localparam int DIV_BITS_PER_STAGE = OFF_W / DIV_SUBSTAGES;
  localparam int NUM_DIV_STAGES     = DIV_DIMS * DIV_SUBSTAGES;
  localparam int NUM_STAGES         = NUM_DIV_STAGES + 2;
  localparam int LAST_STAGE         = NUM_STAGES - 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = EXT_W;

  typedef logic [EXT_W-1:0]      ext_t;
  typedef logic [CRD_W-1:0]      crd_t;
  typedef logic [DIG_W-1:0]      dig_t;
  typedef logic [DIMS_W-1:0]     dims_t;
  typedef logic [DIDX_W-1:0]     didx_t;
  typedef logic [SUB_W-1:0]      sub_t;
  typedef logic [OFF_W-1:0]      off_t;
  typedef logic [ACT_W-1:0]      act_t;
  typedef logic [CFG_IDX_W-1:0]  cidx_t;
  typedef logic [CFG_DATA_W-1:0] cdata_t;

  // Action codes.
  localparam act_t ACT_ENCODE = 2'd0;
  localparam act_t ACT_DECODE = 2'd1;
  localparam act_t ACT_STEP   = 2'd2;

  // Register indexes.
  localparam cidx_t REG_DIMS_USED = 3'd0;
  localparam cidx_t REG_EXTENT_0  = 3'd1;
  localparam cidx_t REG_EXTENT_1  = 3'd2;
  localparam cidx_t REG_EXTENT_2  = 3'd3;
  localparam cidx_t REG_EXTENT_3  = 3'd4;

  // Clamped shape as seen by every pipeline stage.
  typedef struct packed {
    dims_t                         nd;
    logic [NUM_DIMS-1:0][EXT_W-1:0] ext;
  } tic_cfg_t;

  // Work state of one item as it travels down the pipeline.
  typedef struct packed {
    act_t                           act;
    logic [NUM_DIMS-1:0][CRD_W-1:0] res;
    logic [DIV_DIMS-1:0][DIG_W-1:0] term;
    off_t                           acc;
    off_t                           num;
    dig_t                           rem;
    logic                           done;
  } tic_item_t;

  // Finished result as held in the output register.
  typedef struct packed {
    off_t                           offset;
    logic [NUM_DIMS-1:0][CRD_W-1:0] res;
    logic                           done;
    logic                           oor;
  } tic_result_t;

  // An extent of zero reads as one, anything above the limit as the limit.
  function automatic ext_t clamp_ext(input ext_t v);
    ext_t r;
    if (v == '0) begin
      r = ext_t'(1);
    end else if (v > ext_t'(MAX_EXTENT)) begin
      r = ext_t'(MAX_EXTENT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // A dimension count of zero reads as one, anything above the limit as the limit.
  function automatic dims_t clamp_dims(input dims_t v);
    dims_t r;
    if (v == '0) begin
      r = dims_t'(1);
    end else if (v > dims_t'(MAX_DIMS)) begin
      r = dims_t'(MAX_DIMS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/core/tic_front.sv */
module tic_front (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            load,
  input  logic                                            in_valid,
  input  tic_pkg::act_t                                   action,
  input  logic [tic_pkg::NUM_DIMS-1:0][tic_pkg::CRD_W-1:0] coord,
  input  tic_pkg::off_t                                   offset_in,
  input  tic_pkg::tic_cfg_t                               cfg,
  output logic                                            out_valid,
  output tic_pkg::tic_item_t                              out_item
);

  logic [tic_pkg::NUM_DIMS-1:0][tic_pkg::CRD_W-1:0] crd;
  logic [tic_pkg::NUM_DIMS-1:0]                     used;
  logic                                             carry;
  tic_pkg::tic_item_t                               item_next;

  // Clamp the coordinates into their extents and mark the dimensions in use.
  always_comb begin
    for (int i = 0; i < tic_pkg::NUM_DIMS; i++) begin
      if (coord[i] == '0) begin
        crd[i] = tic_pkg::crd_t'(1);
      end else if (coord[i] > cfg.ext[i]) begin
        crd[i] = cfg.ext[i];
      end else begin
        crd[i] = coord[i];
      end
      used[i] = tic_pkg::dims_t'(i) < cfg.nd;
    end
  end

  // Step results, encode seed and the terms that the multiply stages add.
  always_comb begin
    item_next      = '0;
    item_next.act  = action;
    item_next.num  = offset_in;
    item_next.rem  = '0;
    item_next.done = 1'b0;
    carry          = 1'b1;
    for (int i = 0; i < tic_pkg::NUM_DIMS; i++) begin
      item_next.res[i] = tic_pkg::crd_t'(1);
    end

    case (action)
      tic_pkg::ACT_ENCODE: begin
        for (int i = 0; i < tic_pkg::NUM_DIMS; i++) begin
          if (used[i]) begin
            item_next.res[i] = crd[i];
          end
        end
      end
      tic_pkg::ACT_STEP: begin
        for (int i = 0; i < tic_pkg::NUM_DIMS; i++) begin
          if (used[i]) begin
            item_next.res[i] = crd[i];
          end
        end
        // Odometer: the last used dimension moves first and carries downwards.
        for (int i = tic_pkg::NUM_DIMS - 1; i >= 0; i--) begin
          if (used[i] && carry) begin
            if (crd[i] >= cfg.ext[i]) begin
              item_next.res[i] = tic_pkg::crd_t'(1);
            end else begin
              item_next.res[i] = crd[i] + tic_pkg::crd_t'(1);
              carry            = 1'b0;
            end
          end
        end
        item_next.done = carry;
      end
      default: begin
      end
    endcase

    for (int i = 0; i < tic_pkg::DIV_DIMS; i++) begin
      item_next.term[i] = used[i] ? tic_pkg::dig_t'(crd[i] - tic_pkg::crd_t'(1)) : '0;
    end
    item_next.acc = used[tic_pkg::NUM_DIMS-1]
                  ? tic_pkg::off_t'(crd[tic_pkg::NUM_DIMS-1] - tic_pkg::crd_t'(1))
                  : '0;
  end

  // First pipeline register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule

/* rtl/core/tic_div_stage.sv */
module tic_div_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  in_valid,
  input  tic_pkg::tic_item_t    in_item,
  input  tic_pkg::didx_t        dim,
  input  tic_pkg::sub_t         sub,
  input  tic_pkg::tic_cfg_t     cfg,
  output logic                  out_valid,
  output tic_pkg::tic_item_t    out_item
);

  logic                                     first;
  logic                                     last;
  logic                                     div_en;
  tic_pkg::ext_t                            divisor;
  tic_pkg::didx_t                           mul_idx;
  logic [tic_pkg::OFF_W+tic_pkg::EXT_W-1:0] prod;
  tic_pkg::off_t                            num_w;
  tic_pkg::dig_t                            rem_w;
  logic [tic_pkg::DIG_W:0]                  part;
  tic_pkg::tic_item_t                       item_next;

  // Which division this stage belongs to, and which multiply it carries.
  always_comb begin
    first   = sub == '0;
    last    = sub == tic_pkg::sub_t'(tic_pkg::DIV_SUBSTAGES - 1);
    div_en  = (tic_pkg::dims_t'(dim) + tic_pkg::dims_t'(1)) < cfg.nd;
    divisor = cfg.ext[dim];
    mul_idx = tic_pkg::didx_t'(tic_pkg::DIV_DIMS - 1) - dim;
  end

  // Horner step of the encode: acc * extent + term, modulo 2^32.
  always_comb begin
    prod = in_item.acc * cfg.ext[mul_idx];
  end

  // A slice of restoring division: one quotient bit per step, MSB first.
  always_comb begin
    num_w = in_item.num;
    rem_w = first ? '0 : in_item.rem;
    part  = '0;
    for (int b = 0; b < tic_pkg::DIV_BITS_PER_STAGE; b++) begin
      part  = {rem_w, num_w[tic_pkg::OFF_W-1]};
      num_w = {num_w[tic_pkg::OFF_W-2:0], 1'b0};
      if (part >= divisor) begin
        rem_w    = tic_pkg::dig_t'(part - divisor);
        num_w[0] = 1'b1;
      end else begin
        rem_w = part[tic_pkg::DIG_W-1:0];
      end
    end
  end

  // Merge the stage results into the item.
  always_comb begin
    item_next = in_item;
    if (first) begin
      item_next.acc = prod[tic_pkg::OFF_W-1:0] + tic_pkg::off_t'(in_item.term[mul_idx]);
    end
    if (div_en) begin
      item_next.num = num_w;
      item_next.rem = rem_w;
      if (last && in_item.act == tic_pkg::ACT_DECODE) begin
        item_next.res[dim] = tic_pkg::crd_t'(rem_w) + tic_pkg::crd_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule

/* rtl/core/tic_back.sv */
module tic_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  in_valid,
  input  tic_pkg::tic_item_t    in_item,
  input  tic_pkg::tic_cfg_t     cfg,
  output logic                  out_valid,
  output tic_pkg::tic_result_t  result
);

  tic_pkg::didx_t       top;
  tic_pkg::off_t        quot;
  tic_pkg::tic_result_t result_next;

  // The quotient left after the lower divisions is the top coordinate.
  always_comb begin
    top                = tic_pkg::didx_t'(cfg.nd - tic_pkg::dims_t'(1));
    quot               = in_item.num;
    result_next.res    = in_item.res;
    result_next.done   = in_item.done;
    result_next.oor    = 1'b0;
    result_next.offset = (in_item.act == tic_pkg::ACT_ENCODE) ? in_item.acc : '0;
    if (in_item.act == tic_pkg::ACT_DECODE) begin
      if (quot >= tic_pkg::off_t'(tic_pkg::MAX_EXTENT)) begin
        result_next.res[top] = tic_pkg::crd_t'(tic_pkg::MAX_EXTENT);
      end else begin
        result_next.res[top] = tic_pkg::crd_t'(quot) + tic_pkg::crd_t'(1);
      end
      result_next.oor = quot >= tic_pkg::off_t'(cfg.ext[top]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/core/tensor_index_converter.sv */
// Tensor index converter: encodes 1-based coordinates to a linear offset,
// decodes an offset back to coordinates, or steps coordinates in odometer order.
// Input channel in_valid/in_ready carries action, coord_0..coord_3 and offset_in;
// output channel out_valid/out_ready carries offset_out, res_coord_0..res_coord_3,
// walk_done and out_of_range. The user must write the shape (dims_used,
// extent_0..extent_3) via cfg_wr_en/cfg_index/cfg_data while no item is in
// flight; the block does not enforce this. The pipeline has 14 register stages:
// a front stage that clamps and steps, twelve stages that each do eight bits of
// a restoring division by an extent (four per extent, three extents) plus one
// encode multiply every fourth stage, and the output register. One item per
// cycle is sustained while the receiver keeps out_ready high.
// Reset clears every valid bit and sets one dimension of extent one.
// When the receiver stalls, each stage holds its item and empty stages still
// fill, so in_ready falls only once all 14 stages hold items.
module tensor_index_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  tic_pkg::cidx_t    cfg_index,
  input  tic_pkg::cdata_t   cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  tic_pkg::act_t     action,
  input  tic_pkg::crd_t     coord_0,
  input  tic_pkg::crd_t     coord_1,
  input  tic_pkg::crd_t     coord_2,
  input  tic_pkg::crd_t     coord_3,
  input  tic_pkg::off_t     offset_in,
  output logic              out_valid,
  input  logic              out_ready,
  output tic_pkg::off_t     offset_out,
  output tic_pkg::crd_t     res_coord_0,
  output tic_pkg::crd_t     res_coord_1,
  output tic_pkg::crd_t     res_coord_2,
  output tic_pkg::crd_t     res_coord_3,
  output logic              walk_done,
  output logic              out_of_range
);

  tic_pkg::dims_t                                    dims_used;
  logic [tic_pkg::NUM_DIMS-1:0][tic_pkg::EXT_W-1:0]  extent;
  tic_pkg::tic_cfg_t                                 cfg;
  logic [tic_pkg::NUM_STAGES-1:0]                    stg_valid;
  logic [tic_pkg::NUM_STAGES-1:0]                    stg_load;
  tic_pkg::tic_item_t                                stg_item [tic_pkg::NUM_DIV_STAGES+1];
  tic_pkg::tic_result_t                              result;
  logic [tic_pkg::NUM_DIMS-1:0][tic_pkg::CRD_W-1:0]  coord;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_used <= tic_pkg::dims_t'(1);
      for (int i = 0; i < tic_pkg::NUM_DIMS; i++) begin
        extent[i] <= tic_pkg::ext_t'(1);
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tic_pkg::REG_DIMS_USED: dims_used <= cfg_data[tic_pkg::DIMS_W-1:0];
        tic_pkg::REG_EXTENT_0:  extent[0] <= cfg_data;
        tic_pkg::REG_EXTENT_1:  extent[1] <= cfg_data;
        tic_pkg::REG_EXTENT_2:  extent[2] <= cfg_data;
        tic_pkg::REG_EXTENT_3:  extent[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Shape after clamping, shared by every stage.
  always_comb begin
    cfg.nd = tic_pkg::clamp_dims(dims_used);
    for (int i = 0; i < tic_pkg::NUM_DIMS; i++) begin
      cfg.ext[i] = tic_pkg::clamp_ext(extent[i]);
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  assign stg_load[tic_pkg::LAST_STAGE] = !stg_valid[tic_pkg::LAST_STAGE] || out_ready;
  for (genvar k = 0; k < tic_pkg::LAST_STAGE; k++) begin : g_load
    assign stg_load[k] = !stg_valid[k] || stg_load[k+1];
  end
  assign in_ready = stg_load[0];

  assign coord = {coord_3, coord_2, coord_1, coord_0};

  tic_front u_front (
    .clk       (clk),
    .rst       (rst),
    .load      (stg_load[0]),
    .in_valid  (in_valid),
    .action    (action),
    .coord     (coord),
    .offset_in (offset_in),
    .cfg       (cfg),
    .out_valid (stg_valid[0]),
    .out_item  (stg_item[0])
  );

  // Division stages: four per extent, lowest dimension first.
  for (genvar j = 0; j < tic_pkg::NUM_DIV_STAGES; j++) begin : g_div
    tic_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .load      (stg_load[j+1]),
      .in_valid  (stg_valid[j]),
      .in_item   (stg_item[j]),
      .dim       (tic_pkg::didx_t'(j / tic_pkg::DIV_SUBSTAGES)),
      .sub       (tic_pkg::sub_t'(j % tic_pkg::DIV_SUBSTAGES)),
      .cfg       (cfg),
      .out_valid (stg_valid[j+1]),
      .out_item  (stg_item[j+1])
    );
  end

  tic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .load      (stg_load[tic_pkg::LAST_STAGE]),
    .in_valid  (stg_valid[tic_pkg::LAST_STAGE-1]),
    .in_item   (stg_item[tic_pkg::NUM_DIV_STAGES]),
    .cfg       (cfg),
    .out_valid (stg_valid[tic_pkg::LAST_STAGE]),
    .result    (result)
  );

  assign out_valid    = stg_valid[tic_pkg::LAST_STAGE];
  assign offset_out   = result.offset;
  assign res_coord_0  = result.res[0];
  assign res_coord_1  = result.res[1];
  assign res_coord_2  = result.res[2];
  assign res_coord_3  = result.res[3];
  assign walk_done    = result.done;
  assign out_of_range = result.oor;

  // A taken result frees the whole pipeline, so input must be ready.
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // An item waiting behind a stalled output register must not be lost.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (stg_valid[tic_pkg::LAST_STAGE-1] && !stg_load[tic_pkg::LAST_STAGE])
    |=> stg_valid[tic_pkg::LAST_STAGE-1])
    else $error("item dropped in front of stalled output");

  // Every presented coordinate lies between one and the extent limit.
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_coord_0 != '0 && res_coord_1 != '0 &&
                   res_coord_2 != '0 && res_coord_3 != '0 &&
                   res_coord_0 <= tic_pkg::crd_t'(tic_pkg::MAX_EXTENT) &&
                   res_coord_1 <= tic_pkg::crd_t'(tic_pkg::MAX_EXTENT) &&
                   res_coord_2 <= tic_pkg::crd_t'(tic_pkg::MAX_EXTENT) &&
                   res_coord_3 <= tic_pkg::crd_t'(tic_pkg::MAX_EXTENT)))
    else $error("result coordinate out of range");

  // A step flag and a decode flag never come from the same item.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(walk_done && out_of_range))
    else $error("walk_done and out_of_range both set");

endmodule
